// File: rtl/mra_pkg.sv
// Shared constants, stage payload types and fixed-point helpers for the modulation route core.
package mra_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int LVL_W         = FRACTION_BITS + 1;
  localparam int SMP_W         = FRACTION_BITS + 2;
  localparam int PROD_W        = 2 * LVL_W;

  // Divider: one quotient bit per step, a fixed number of steps per register stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (FRACTION_BITS + DIV_STEPS - 1) / DIV_STEPS;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam lvl_t ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam lvl_t HALF = {2'b01, {(FRACTION_BITS-1){1'b0}}};
  localparam prod_t RND = {{(PROD_W-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

  localparam logic signed [SMP_W-1:0] S_ONE  = $signed({1'b0, ONE});
  localparam logic signed [SMP_W-1:0] S_MONE = -S_ONE;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  localparam logic [1:0] MODE_UNI = 2'd0;
  localparam logic [1:0] MODE_BIP = 2'd1;
  localparam logic [1:0] MODE_KEY = 2'd2;

  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_ONE  = 2'd1,
    K_DIV  = 2'd2
  } kcase_t;

  typedef struct packed {
    logic       bip;
    logic       key;
    logic [1:0] op;
    lvl_t       amt;
    lvl_t       ofs;
    lvl_t       tgt;
    lvl_t       x;
    prod_t      m1;
  } s1_t;

  typedef struct packed {
    logic       bip;
    logic       key;
    logic [1:0] op;
    lvl_t       amt;
    lvl_t       ofs;
    lvl_t       tgt;
    lvl_t       x;
    lvl_t       hi;
    prod_t      m2;
  } s2_t;

  typedef struct packed {
    logic       bip;
    logic       key;
    logic [1:0] op;
    lvl_t       amt;
    lvl_t       tgt;
    logic       neg;
    lvl_t       mag;
    kcase_t     kcase;
    lvl_t       rem;
    lvl_t       quo;
    lvl_t       dvs;
  } s3_t;

  typedef struct packed {
    logic       bip;
    logic [1:0] op;
    lvl_t       amt;
    lvl_t       tgt;
    logic       neg;
    prod_t      m3;
  } s4_t;

  typedef struct packed {
    logic [1:0] op;
    lvl_t       tgt;
    logic       neg;
    prod_t      ma;
    prod_t      mb;
  } s5_t;

  function automatic lvl_t sat_level(input lvl_t raw);
    return (raw > ONE) ? ONE : raw;
  endfunction

  // Rescale a Q product to Q format, round to nearest with ties up.
  function automatic lvl_t qround(input prod_t p);
    prod_t sum;
    sum = p + RND;
    return sum[FRACTION_BITS +: LVL_W];
  endfunction

  function automatic prod_t qmul_raw(input lvl_t a, input lvl_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

// File: rtl/mra_shape.sv
// Front of the pipeline: input saturation and the three source shaping stages.
module mra_shape (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [1:0]               op,
  input  logic [1:0]               source_mode,
  input  logic signed [mra_pkg::SMP_W-1:0] source_sample,
  input  mra_pkg::lvl_t            amount,
  input  mra_pkg::lvl_t            scale_level,
  input  mra_pkg::lvl_t            offset_level,
  input  mra_pkg::lvl_t            target_value,
  output logic                     vld,
  output mra_pkg::s3_t             data
);

  logic          v1_r, v2_r, v3_r;
  mra_pkg::s1_t  s1_r, s1_nxt;
  mra_pkg::s2_t  s2_r, s2_nxt;
  mra_pkg::s3_t  s3_r, s3_nxt;

  // Stage 1: saturate the levels, clamp the source and form the first product.
  always_comb begin
    logic signed [mra_pkg::SMP_W-1:0] xb;
    logic [mra_pkg::SMP_W-1:0]        ub;
    mra_pkg::lvl_t                    xu;
    mra_pkg::lvl_t                    u;
    mra_pkg::lvl_t                    scl;
    mra_pkg::lvl_t                    ma;
    mra_pkg::lvl_t                    mb;
    s1_nxt.bip = (source_mode == mra_pkg::MODE_BIP);
    s1_nxt.key = (source_mode == mra_pkg::MODE_KEY);
    s1_nxt.op  = op;
    s1_nxt.amt = mra_pkg::sat_level(amount);
    s1_nxt.ofs = mra_pkg::sat_level(offset_level);
    s1_nxt.tgt = mra_pkg::sat_level(target_value);
    scl        = mra_pkg::sat_level(scale_level);
    if (source_sample > mra_pkg::S_ONE) begin
      xb = mra_pkg::S_ONE;
    end else if (source_sample < mra_pkg::S_MONE) begin
      xb = mra_pkg::S_MONE;
    end else begin
      xb = source_sample;
    end
    ub = xb + mra_pkg::S_ONE;
    u  = ub[mra_pkg::SMP_W-1:1];
    if (source_sample[mra_pkg::SMP_W-1]) begin
      xu = '0;
    end else if (source_sample > mra_pkg::S_ONE) begin
      xu = mra_pkg::ONE;
    end else begin
      xu = source_sample[mra_pkg::LVL_W-1:0];
    end
    s1_nxt.x = xu;
    if (s1_nxt.key) begin
      ma = mra_pkg::ONE - s1_nxt.ofs;
      mb = scl;
    end else begin
      ma = scl;
      mb = s1_nxt.bip ? u : xu;
    end
    s1_nxt.m1 = mra_pkg::qmul_raw(ma, mb);
  end

  // Stage 2: high key bound, or the offset-room product for the other sources.
  always_comb begin
    mra_pkg::lvl_t t1;
    t1         = mra_pkg::qround(s1_r.m1);
    s2_nxt.bip = s1_r.bip;
    s2_nxt.key = s1_r.key;
    s2_nxt.op  = s1_r.op;
    s2_nxt.amt = s1_r.amt;
    s2_nxt.ofs = s1_r.ofs;
    s2_nxt.tgt = s1_r.tgt;
    s2_nxt.x   = s1_r.x;
    s2_nxt.hi  = s1_r.ofs + t1;
    s2_nxt.m2  = mra_pkg::qmul_raw(mra_pkg::ONE - s1_r.ofs, t1);
  end

  // Stage 3: finish the shaped level and set up the key-tracking division.
  always_comb begin
    mra_pkg::lvl_t             s;
    logic [mra_pkg::LVL_W:0]   twos;
    mra_pkg::lvl_t             diff;
    mra_pkg::lvl_t             span;
    logic                      q_top;
    s          = s2_r.ofs + mra_pkg::qround(s2_r.m2);
    twos       = {s, 1'b0};
    diff       = s2_r.x - s2_r.ofs;
    span       = s2_r.hi - s2_r.ofs;
    q_top      = (diff == span);
    s3_nxt.bip = s2_r.bip;
    s3_nxt.key = s2_r.key;
    s3_nxt.op  = s2_r.op;
    s3_nxt.amt = s2_r.amt;
    s3_nxt.tgt = s2_r.tgt;
    s3_nxt.dvs = span;
    s3_nxt.rem = q_top ? '0 : diff;
    s3_nxt.quo = {{(mra_pkg::LVL_W-1){1'b0}}, q_top};
    if (s2_r.bip) begin
      // Map back to bipolar as sign and magnitude of 2s - 1.
      if (s >= mra_pkg::HALF) begin
        s3_nxt.neg = 1'b0;
        s3_nxt.mag = mra_pkg::LVL_W'(twos - {1'b0, mra_pkg::ONE});
      end else begin
        s3_nxt.neg = 1'b1;
        s3_nxt.mag = mra_pkg::LVL_W'({1'b0, mra_pkg::ONE} - twos);
      end
    end else begin
      s3_nxt.neg = 1'b0;
      s3_nxt.mag = s;
    end
    if (s2_r.x < s2_r.ofs) begin
      s3_nxt.kcase = mra_pkg::K_ZERO;
    end else if (s2_r.x > s2_r.hi) begin
      s3_nxt.kcase = mra_pkg::K_ONE;
    end else if (s2_r.hi == s2_r.ofs) begin
      s3_nxt.kcase = mra_pkg::K_ZERO;
    end else begin
      s3_nxt.kcase = mra_pkg::K_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign vld  = v3_r;
  assign data = s3_r;

endmodule

// File: rtl/mra_div.sv
// Pipelined restoring divider for the key-tracking stretch; carries the item alongside.
module mra_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  mra_pkg::s3_t  in_data,
  output logic          out_vld,
  output mra_pkg::s3_t  out_data
);

  logic [mra_pkg::DIV_STAGES-1:0] vld_r;
  mra_pkg::s3_t                   pipe_r   [mra_pkg::DIV_STAGES];
  mra_pkg::s3_t                   pipe_nxt [mra_pkg::DIV_STAGES];
  mra_pkg::s3_t                   stage_in [mra_pkg::DIV_STAGES];

  for (genvar j = 0; j < mra_pkg::DIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign stage_in[j] = in_data;
    end else begin : g_next
      assign stage_in[j] = pipe_r[j-1];
    end

    always_comb begin
      mra_pkg::s3_t              cur;
      logic [mra_pkg::LVL_W:0]   dbl;
      cur = stage_in[j];
      dbl = '0;
      for (int i = 0; i < mra_pkg::DIV_STEPS; i++) begin
        if (j * mra_pkg::DIV_STEPS + i < mra_pkg::FRACTION_BITS) begin
          dbl = {cur.rem, 1'b0};
          if (dbl >= {1'b0, cur.dvs}) begin
            cur.rem = mra_pkg::LVL_W'(dbl - {1'b0, cur.dvs});
            cur.quo = {cur.quo[mra_pkg::LVL_W-2:0], 1'b1};
          end else begin
            cur.rem = dbl[mra_pkg::LVL_W-1:0];
            cur.quo = {cur.quo[mra_pkg::LVL_W-2:0], 1'b0};
          end
        end
      end
      pipe_nxt[j] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= (j == 0) ? in_vld : vld_r[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe_r[j] <= pipe_nxt[j];
      end
    end
  end

  assign out_vld  = vld_r[mra_pkg::DIV_STAGES-1];
  assign out_data = pipe_r[mra_pkg::DIV_STAGES-1];

endmodule

// File: rtl/mra_combine.sv
// Back of the pipeline: amount scaling, combine with the target, and output clamp.
module mra_combine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  mra_pkg::s3_t  in_data,
  output logic          out_vld,
  output mra_pkg::lvl_t out_value
);

  logic           v4_r, v5_r, vo_r;
  mra_pkg::s4_t   s4_r, s4_nxt;
  mra_pkg::s5_t   s5_r, s5_nxt;
  mra_pkg::lvl_t  res_r, res_nxt;

  // First stage: pick the shaped level and scale it by the amount.
  always_comb begin
    mra_pkg::lvl_t kval;
    mra_pkg::lvl_t lvl;
    case (in_data.kcase)
      mra_pkg::K_ZERO: kval = '0;
      mra_pkg::K_ONE:  kval = mra_pkg::ONE;
      mra_pkg::K_DIV:  kval = in_data.quo;
      default:         kval = '0;
    endcase
    lvl        = in_data.key ? kval : in_data.mag;
    s4_nxt.bip = in_data.bip;
    s4_nxt.op  = in_data.op;
    s4_nxt.amt = in_data.amt;
    s4_nxt.tgt = in_data.tgt;
    s4_nxt.neg = in_data.neg;
    s4_nxt.m3  = mra_pkg::qmul_raw(in_data.amt, lvl);
  end

  // Second stage: combine products.
  always_comb begin
    mra_pkg::lvl_t sh;
    mra_pkg::lvl_t room;
    mra_pkg::lvl_t inv;
    sh         = mra_pkg::qround(s4_r.m3);
    inv        = mra_pkg::ONE - s4_r.tgt;
    room       = (s4_r.tgt < inv) ? s4_r.tgt : inv;
    s5_nxt.op  = s4_r.op;
    s5_nxt.tgt = s4_r.tgt;
    s5_nxt.neg = s4_r.neg;
    s5_nxt.mb  = '0;
    case (s4_r.op)
      mra_pkg::OP_ADD: s5_nxt.ma = mra_pkg::qmul_raw(s4_r.bip ? room : inv, sh);
      mra_pkg::OP_SUB: s5_nxt.ma = mra_pkg::qmul_raw(s4_r.bip ? room : s4_r.tgt, sh);
      mra_pkg::OP_MUL: begin
        if (s4_r.bip) begin
          s5_nxt.ma = mra_pkg::qmul_raw(s4_r.tgt, sh);
          s5_nxt.mb = mra_pkg::qmul_raw(mra_pkg::ONE - s4_r.amt, s4_r.tgt);
        end else begin
          s5_nxt.ma = mra_pkg::qmul_raw(mra_pkg::ONE - s4_r.amt + sh, s4_r.tgt);
        end
      end
      default: s5_nxt.ma = '0;
    endcase
  end

  // Last stage: signed sum and saturation to [0,1].
  always_comb begin
    logic signed [mra_pkg::LVL_W+1:0] tgt_s;
    logic signed [mra_pkg::LVL_W+1:0] pa_s;
    logic signed [mra_pkg::LVL_W+1:0] pb_s;
    logic signed [mra_pkg::LVL_W+1:0] dlt_s;
    logic signed [mra_pkg::LVL_W+1:0] rs;
    tgt_s = $signed({2'b00, s5_r.tgt});
    pa_s  = $signed({2'b00, mra_pkg::qround(s5_r.ma)});
    pb_s  = $signed({2'b00, mra_pkg::qround(s5_r.mb)});
    dlt_s = s5_r.neg ? -pa_s : pa_s;
    case (s5_r.op)
      mra_pkg::OP_ADD: rs = tgt_s + dlt_s;
      mra_pkg::OP_SUB: rs = tgt_s - dlt_s;
      mra_pkg::OP_MUL: rs = pa_s + pb_s;
      default:         rs = tgt_s;
    endcase
    if (rs < 0) begin
      res_nxt = '0;
    end else if (rs > $signed({2'b00, mra_pkg::ONE})) begin
      res_nxt = mra_pkg::ONE;
    end else begin
      res_nxt = rs[mra_pkg::LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_vld;
      v5_r <= v4_r;
      vo_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld   = vo_r;
  assign out_value = res_r;

endmodule

// File: rtl/modulation_route_apply_core.sv
// Each request passes through the shaping, divider and combine stages in that order.
// Throughput: one request per clock when not stalled; the 16 key-tracking quotient bits
// are spread over four divider stages of four steps, which sets the pipeline depth.
// All stages advance together; a stalled output freezes the whole pipeline in place.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
// Top level of the modulation route apply pipeline.
module modulation_route_apply_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [1:0]                        in_source_mode,
  input  logic signed [mra_pkg::SMP_W-1:0]  in_source_sample,
  input  logic [mra_pkg::LVL_W-1:0]         in_amount,
  input  logic [mra_pkg::LVL_W-1:0]         in_scale_level,
  input  logic [mra_pkg::LVL_W-1:0]         in_offset_level,
  input  logic [mra_pkg::LVL_W-1:0]         in_target_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mra_pkg::LVL_W-1:0]         out_modulated_value
);

  // The pipeline moves whenever the output register is empty or being taken.
  // An empty output slot lets every stage shift, so bubbles never hold up a request.
  logic         adv;
  logic         shp_vld;
  mra_pkg::s3_t shp_data;
  logic         div_vld;
  mra_pkg::s3_t div_data;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stages 1 to 3: level saturation, source clamp, and shaping by scale and offset.
  // Key tracking computes its high bound here and primes the divider.
  mra_shape u_shape (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (in_valid),
    .op            (in_op),
    .source_mode   (in_source_mode),
    .source_sample (in_source_sample),
    .amount        (in_amount),
    .scale_level   (in_scale_level),
    .offset_level  (in_offset_level),
    .target_value  (in_target_value),
    .vld           (shp_vld),
    .data          (shp_data)
  );

  // Stages 4 to 7: the key-tracking quotient, one bit per step. Requests of the
  // other source kinds ride along unchanged so that every request sees the same latency.
  mra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (shp_vld),
    .in_data  (shp_data),
    .out_vld  (div_vld),
    .out_data (div_data)
  );

  // Stages 8 to 10: amount scaling, combine into the target, clamp to [0,1].
  // The last stage is the output register.
  mra_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (div_vld),
    .in_data   (div_data),
    .out_vld   (out_valid),
    .out_value (out_modulated_value)
  );

endmodule

// File: rtl/mra_checker.sv
// Port-level checks for the modulation route core, bound to the top level.
module mra_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mra_pkg::LVL_W-1:0] out_modulated_value
);

  // The input is held back exactly when a finished result is waiting.
  a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match a blocked output");

  // A stalled result stays and keeps its value.
  a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_modulated_value))
    else $error("stalled result changed or vanished");

  // Every result is saturated to at most one.
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_modulated_value <= mra_pkg::ONE)
    else $error("result above one");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind modulation_route_apply_core mra_checker u_mra_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_modulated_value (out_modulated_value)
);
